### design/bchd_pkg.sv
package bchd_pkg;

    // Event codes carried on event_code
    localparam logic [2:0] EV_NONE    = 3'd0;
    localparam logic [2:0] EV_CLICK   = 3'd1;
    localparam logic [2:0] EV_DOUBLE  = 3'd2;
    localparam logic [2:0] EV_RELEASE = 3'd3;
    localparam logic [2:0] EV_HOLD    = 3'd4;
    localparam logic [2:0] EV_REPEAT  = 3'd5;

    // Configuration register indexes
    localparam logic [2:0] CFG_DEBOUNCE_LIMIT  = 3'd0;
    localparam logic [2:0] CFG_DOUBLE_CLICK_MS = 3'd1;
    localparam logic [2:0] CFG_HOLD_MS         = 3'd2;
    localparam logic [2:0] CFG_REPEAT_START_MS = 3'd3;
    localparam logic [2:0] CFG_REPEAT_FLOOR_MS = 3'd4;
    localparam logic [2:0] CFG_REPEAT_STEP_MS  = 3'd5;

    // Reset values of the configuration registers
    localparam logic [7:0]  RST_DEBOUNCE_LIMIT  = 8'd5;
    localparam logic [15:0] RST_DOUBLE_CLICK_MS = 16'd300;
    localparam logic [15:0] RST_HOLD_MS         = 16'd500;
    localparam logic [15:0] RST_REPEAT_START_MS = 16'd300;
    localparam logic [15:0] RST_REPEAT_FLOOR_MS = 16'd50;
    localparam logic [15:0] RST_REPEAT_STEP_MS  = 16'd25;

    // Run counters hold up to debounce_limit + 1
    localparam int RUN_W = 9;

    typedef struct packed {
        logic [7:0]  debounce_limit;
        logic [15:0] double_click_ms;
        logic [15:0] hold_ms;
        logic [15:0] repeat_start_ms;
        logic [15:0] repeat_floor_ms;
        logic [15:0] repeat_step_ms;
    } cfg_t;

endpackage

### design/bchd_debounce.sv
module bchd_debounce (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       advance,
    input  logic       poll,
    input  logic       pin_level,
    input  logic [7:0] debounce_limit,
    output logic       deb_next
);
    import bchd_pkg::*;

    logic [RUN_W-1:0] down_run_reg, down_run_next;
    logic [RUN_W-1:0] up_run_reg, up_run_next;
    logic             deb_reg;
    logic [RUN_W-1:0] limit_ext;
    logic             is_down;

    assign limit_ext = {1'b0, debounce_limit};
    assign is_down   = ~pin_level;

    // Run counters: a level is taken once it persists beyond the limit
    always_comb
    begin
        down_run_next = down_run_reg;
        up_run_next   = up_run_reg;
        deb_next      = deb_reg;
        if (poll)
        begin
            if (is_down)
            begin
                if (down_run_reg > limit_ext)
                begin
                    deb_next      = 1'b1;
                    down_run_next = RUN_W'(1);
                end
                else
                begin
                    down_run_next = down_run_reg + RUN_W'(1);
                end
                up_run_next = '0;
            end
            else
            begin
                if (up_run_reg > limit_ext)
                begin
                    deb_next    = 1'b0;
                    up_run_next = RUN_W'(1);
                end
                else
                begin
                    up_run_next = up_run_reg + RUN_W'(1);
                end
                down_run_next = '0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            down_run_reg <= '0;
            up_run_reg   <= '0;
            deb_reg      <= 1'b0;
        end
        else if (advance)
        begin
            down_run_reg <= down_run_next;
            up_run_reg   <= up_run_next;
            deb_reg      <= deb_next;
        end
    end

endmodule

### design/bchd_events.sv
module bchd_events (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          advance,
    input  logic          deb_next,
    input  logic [31:0]   now_ms,
    input  bchd_pkg::cfg_t cfg,
    output logic [2:0]    code
);
    import bchd_pkg::*;

    logic        reported_reg, reported_next;
    logic [31:0] press_time_reg, press_time_next;
    logic [31:0] repeat_time_reg, repeat_time_next;
    logic        second_armed_reg, second_armed_next;
    logic        hold_armed_reg, hold_armed_next;
    logic        repeat_armed_reg, repeat_armed_next;
    logic [15:0] interval_reg, interval_next;

    logic [31:0] press_gap;
    logic [31:0] repeat_gap;
    logic [15:0] above_floor;

    assign press_gap   = now_ms - press_time_reg;
    assign repeat_gap  = now_ms - repeat_time_reg;
    assign above_floor = interval_reg - cfg.repeat_floor_ms;

    // Event decision for one transaction
    always_comb
    begin
        reported_next     = reported_reg;
        press_time_next   = press_time_reg;
        repeat_time_next  = repeat_time_reg;
        second_armed_next = second_armed_reg;
        hold_armed_next   = hold_armed_reg;
        repeat_armed_next = repeat_armed_reg;
        interval_next     = interval_reg;
        code              = EV_NONE;
        if (reported_reg != deb_next)
        begin
            reported_next = deb_next;
            if (deb_next)
            begin
                press_time_next = now_ms;
                if ((press_gap < {16'd0, cfg.double_click_ms}) && second_armed_reg)
                begin
                    second_armed_next = 1'b0;
                    code              = EV_DOUBLE;
                end
                else
                begin
                    second_armed_next = 1'b1;
                    code              = EV_CLICK;
                end
            end
            else
            begin
                code              = EV_RELEASE;
                hold_armed_next   = 1'b1;
                repeat_armed_next = 1'b0;
                interval_next     = cfg.repeat_start_ms;
            end
        end
        else if (deb_next)
        begin
            // hold restarts the repeat timer, so no repeat in the same step
            if (hold_armed_reg && (press_gap > {16'd0, cfg.hold_ms}))
            begin
                hold_armed_next   = 1'b0;
                repeat_armed_next = 1'b1;
                repeat_time_next  = now_ms;
                code              = EV_HOLD;
            end
            else if (repeat_armed_reg && (repeat_gap > {16'd0, interval_reg}))
            begin
                code             = EV_REPEAT;
                repeat_time_next = now_ms;
                if (interval_reg > cfg.repeat_floor_ms)
                begin
                    if (above_floor > cfg.repeat_step_ms)
                        interval_next = interval_reg - cfg.repeat_step_ms;
                    else
                        interval_next = cfg.repeat_floor_ms;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            reported_reg     <= 1'b0;
            press_time_reg   <= '0;
            repeat_time_reg  <= '0;
            second_armed_reg <= 1'b0;
            hold_armed_reg   <= 1'b1;
            repeat_armed_reg <= 1'b0;
            interval_reg     <= RST_REPEAT_START_MS;
        end
        else if (advance)
        begin
            reported_reg     <= reported_next;
            press_time_reg   <= press_time_next;
            repeat_time_reg  <= repeat_time_next;
            second_armed_reg <= second_armed_next;
            hold_armed_reg   <= hold_armed_next;
            repeat_armed_reg <= repeat_armed_next;
            interval_reg     <= interval_next;
        end
    end

    // hold and repeat phases never overlap
    a_arm_exclusive: assert property (@(posedge clk) disable iff (!rst_n)
        !(hold_armed_reg && repeat_armed_reg))
        else $error("hold and repeat armed together");

    // a press event only with the switch down
    a_press_down: assert property (@(posedge clk) disable iff (!rst_n)
        (advance && (code == EV_CLICK || code == EV_DOUBLE)) |-> deb_next)
        else $error("press event with switch up");

    // release rearms the hold
    a_release_rearm: assert property (@(posedge clk) disable iff (!rst_n)
        (advance && code == EV_RELEASE) |=> (hold_armed_reg && !repeat_armed_reg))
        else $error("release did not rearm hold");

    // interval moves only with a transaction
    a_interval_hold: assert property (@(posedge clk) disable iff (!rst_n)
        !advance |=> $stable(interval_reg))
        else $error("repeat interval changed without transaction");

endmodule

### design/button_click_hold_detector.sv
// Button click/hold detector. Each input transaction is one poll call
// (raw pin, poll flag, ms timestamp) and yields exactly one result
// transaction (event_code, pressed). It passes the input register, then the
// output register; one transaction is accepted per cycle while out_stall is
// low, as the debounce and event state update in the single pass between
// those registers. Configuration writes take effect at the next transaction;
// a new repeat_start_ms is used from the next release on.
module button_click_hold_detector (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic        pin_level,
    input  logic        poll_due,
    input  logic [31:0] now_ms,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [2:0]  event_code,
    output logic        pressed,
    input  logic        cfg_we,
    input  logic [2:0]  cfg_index,
    input  logic [15:0] cfg_data
);
    import bchd_pkg::*;

    cfg_t        cfg_reg;
    logic        s1_valid_reg;
    logic        s1_pin_reg;
    logic        s1_poll_reg;
    logic [31:0] s1_now_reg;
    logic        out_valid_reg;
    logic [2:0]  code_reg;
    logic        pressed_reg;

    logic        advance;
    logic        deb_next;
    logic [2:0]  code;

    // Stage 1 moves on when the output register is free or being drained
    assign advance  = s1_valid_reg && (!out_valid_reg || !out_stall);
    assign in_stall = s1_valid_reg && !advance;

    // Configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.debounce_limit  <= RST_DEBOUNCE_LIMIT;
            cfg_reg.double_click_ms <= RST_DOUBLE_CLICK_MS;
            cfg_reg.hold_ms         <= RST_HOLD_MS;
            cfg_reg.repeat_start_ms <= RST_REPEAT_START_MS;
            cfg_reg.repeat_floor_ms <= RST_REPEAT_FLOOR_MS;
            cfg_reg.repeat_step_ms  <= RST_REPEAT_STEP_MS;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_DEBOUNCE_LIMIT:  cfg_reg.debounce_limit  <= cfg_data[7:0];
                CFG_DOUBLE_CLICK_MS: cfg_reg.double_click_ms <= cfg_data;
                CFG_HOLD_MS:         cfg_reg.hold_ms         <= cfg_data;
                CFG_REPEAT_START_MS: cfg_reg.repeat_start_ms <= cfg_data;
                CFG_REPEAT_FLOOR_MS: cfg_reg.repeat_floor_ms <= cfg_data;
                CFG_REPEAT_STEP_MS:  cfg_reg.repeat_step_ms  <= cfg_data;
                default:             ;
            endcase
        end
    end

    // Input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s1_valid_reg <= 1'b0;
        else if (in_valid && !in_stall)
            s1_valid_reg <= 1'b1;
        else if (advance)
            s1_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && !in_stall)
        begin
            s1_pin_reg  <= pin_level;
            s1_poll_reg <= poll_due;
            s1_now_reg  <= now_ms;
        end
    end

    bchd_debounce u_debounce (
        .clk            (clk),
        .rst_n          (rst_n),
        .advance        (advance),
        .poll           (s1_poll_reg),
        .pin_level      (s1_pin_reg),
        .debounce_limit (cfg_reg.debounce_limit),
        .deb_next       (deb_next)
    );

    bchd_events u_events (
        .clk     (clk),
        .rst_n   (rst_n),
        .advance (advance),
        .deb_next(deb_next),
        .now_ms  (s1_now_reg),
        .cfg     (cfg_reg),
        .code    (code)
    );

    // Output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (advance)
            out_valid_reg <= 1'b1;
        else if (!out_stall)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            code_reg    <= code;
            pressed_reg <= deb_next;
        end
    end

    assign out_valid  = out_valid_reg;
    assign event_code = code_reg;
    assign pressed    = pressed_reg;

endmodule
